// ----- rtl/cdlc_pkg.sv -----
// Shared types and constants for the configurable day length clock.
`timescale 1ns / 1ps
package cdlc_pkg;

  // Field widths.
  localparam int HOUR_W = 13;
  localparam int TENS_W = 3;
  localparam int UNITS_W = 4;
  localparam int BODY_MIN_W = 6;
  localparam int LIM_MIN_W = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;

  // Normalization constants.
  localparam logic [HOUR_W-1:0] MIN_DAY_HOURS = 13'd2;
  localparam logic [LIM_MIN_W-1:0] HALF_MIN_CAP = 6'd28;
  localparam logic [LIM_MIN_W-1:0] HALF_HOUR_MINUTES = 6'd30;

  // Digit limits.
  localparam logic [TENS_W-1:0] TENS_MAX = 3'd5;
  localparam logic [UNITS_W-1:0] UNITS_MAX = 4'd9;

  // Request kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BODY_HOURS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_MINUTES = 1'b1;

  // One input request.
  typedef struct packed {
    logic               kind;
    logic [HOUR_W-1:0]  load_hours;
    logic [TENS_W-1:0]  load_minute_tens;
    logic [UNITS_W-1:0] load_minute_units;
    logic [TENS_W-1:0]  load_second_tens;
    logic [UNITS_W-1:0] load_second_units;
  } item_t;

  // One result.
  typedef struct packed {
    logic [HOUR_W-1:0]  hours_now;
    logic [TENS_W-1:0]  minute_tens_now;
    logic [UNITS_W-1:0] minute_units_now;
    logic [TENS_W-1:0]  second_tens_now;
    logic [UNITS_W-1:0] second_units_now;
    logic [HOUR_W-1:0]  half_day_hours;
    logic               is_afternoon;
    logic               wrapped;
  } result_t;

  // Normalized day limits.
  typedef struct packed {
    logic [HOUR_W-1:0]    lh;
    logic [LIM_MIN_W-1:0] lm;
    logic [HOUR_W-1:0]    half;
  } limits_t;

endpackage

// ----- rtl/cdlc_limits.sv -----
// Normalization of the configured day length into hour and minute limits.
`timescale 1ns / 1ps
module cdlc_limits (
  input  logic [cdlc_pkg::HOUR_W-1:0]     body_hours,
  input  logic [cdlc_pkg::BODY_MIN_W-1:0] body_minutes,
  output cdlc_pkg::limits_t               lim
);
  import cdlc_pkg::*;

  logic [HOUR_W-1:0]    h_floor;
  logic [HOUR_W-1:0]    h_even;
  logic [LIM_MIN_W-1:0] m_half;
  logic [LIM_MIN_W-1:0] m_capped;
  logic [LIM_MIN_W-1:0] m_total;

  // Floor the hours, halve the minutes, round them down to even and cap them at 28.
  always_comb begin
    h_floor = (body_hours < MIN_DAY_HOURS) ? MIN_DAY_HOURS : body_hours;
    m_half = {1'b0, body_minutes[BODY_MIN_W-1:2], 1'b0};
    m_capped = (m_half > HALF_MIN_CAP) ? HALF_MIN_CAP : m_half;
    // An odd hour count folds half an hour into the minute limit.
    h_even = {h_floor[HOUR_W-1:1], 1'b0};
    m_total = h_floor[0] ? (m_capped + HALF_HOUR_MINUTES) : m_capped;
    // A fractional day gets one extra hour slot.
    lim.lh = (m_total != '0) ? (h_even + 13'd1) : h_even;
    lim.lm = m_total;
    lim.half = {1'b0, lim.lh[HOUR_W-1:1]};
  end

endmodule

// ----- rtl/cdlc_time_core.sv -----
// Time digit state, tick and load logic, and the result register.
`timescale 1ns / 1ps
module cdlc_time_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  cdlc_pkg::item_t   item,
  input  cdlc_pkg::limits_t lim,
  output cdlc_pkg::result_t result
);
  import cdlc_pkg::*;

  logic [HOUR_W-1:0]  hour_reg;
  logic [TENS_W-1:0]  min_tens_reg;
  logic [UNITS_W-1:0] min_units_reg;
  logic [TENS_W-1:0]  sec_tens_reg;
  logic [UNITS_W-1:0] sec_units_reg;

  logic [HOUR_W-1:0]  hour_next;
  logic [TENS_W-1:0]  min_tens_next;
  logic [UNITS_W-1:0] min_units_next;
  logic [TENS_W-1:0]  sec_tens_next;
  logic [UNITS_W-1:0] sec_units_next;
  logic               wrap_next;
  logic [HOUR_W-1:0]  std12_next;
  logic               pm_next;

  logic               lm_zero;
  logic               mins_full;
  logic               secs_full;
  logic [6:0]         min_value;
  logic [LIM_MIN_W-1:0] lm_m1;
  logic               wrap_even;
  logic               wrap_frac;
  logic               at_half;
  logic               c_sec_units;
  logic               c_sec_tens;
  logic               c_min_units;
  logic               c_min_tens;

  // Wrap conditions on the current time.
  always_comb begin
    lm_zero = (lim.lm == '0);
    mins_full = (min_tens_reg == TENS_MAX) && (min_units_reg == UNITS_MAX);
    secs_full = (sec_tens_reg == TENS_MAX) && (sec_units_reg == UNITS_MAX);
    min_value = 7'({min_tens_reg, 3'b000}) + 7'({min_tens_reg, 1'b0}) + 7'(min_units_reg);
    lm_m1 = lim.lm - 6'd1;
    at_half = (hour_reg == lim.half);
    wrap_even = lm_zero && (hour_reg >= (lim.lh - 13'd1)) && mins_full && secs_full;
    wrap_frac = !lm_zero && (at_half || (hour_reg >= lim.lh)) &&
                (min_value >= 7'(lm_m1)) && secs_full;
  end

  // Carry chain of the digit counter.
  always_comb begin
    c_sec_units = (sec_units_reg == UNITS_MAX);
    c_sec_tens = c_sec_units && (sec_tens_reg == TENS_MAX);
    c_min_units = c_sec_tens && (min_units_reg == UNITS_MAX);
    c_min_tens = c_min_units && (min_tens_reg == TENS_MAX);
  end

  // Next time: load with clamping, wrap, or one-second advance.
  always_comb begin
    wrap_next = 1'b0;
    if (item.kind == KIND_LOAD) begin
      hour_next = (item.load_hours > lim.lh) ? lim.lh : item.load_hours;
      min_tens_next = (item.load_minute_tens > TENS_MAX) ? TENS_MAX : item.load_minute_tens;
      min_units_next = (item.load_minute_units > UNITS_MAX) ? UNITS_MAX
                                                             : item.load_minute_units;
      sec_tens_next = (item.load_second_tens > TENS_MAX) ? TENS_MAX : item.load_second_tens;
      sec_units_next = (item.load_second_units > UNITS_MAX) ? UNITS_MAX
                                                             : item.load_second_units;
    end else if (wrap_even || wrap_frac) begin
      wrap_next = 1'b1;
      hour_next = (wrap_frac && at_half) ? (lim.half + 13'd1) : '0;
      min_tens_next = '0;
      min_units_next = '0;
      sec_tens_next = '0;
      sec_units_next = '0;
    end else begin
      sec_units_next = c_sec_units ? '0 : (sec_units_reg + 4'd1);
      sec_tens_next = c_sec_units ? (c_sec_tens ? '0 : (sec_tens_reg + 3'd1)) : sec_tens_reg;
      min_units_next = c_sec_tens ? (c_min_units ? '0 : (min_units_reg + 4'd1))
                                  : min_units_reg;
      min_tens_next = c_min_units ? (c_min_tens ? '0 : (min_tens_reg + 3'd1))
                                  : min_tens_reg;
      hour_next = c_min_tens ? (hour_reg + 13'd1) : hour_reg;
    end
  end

  // Twelve-hour view and afternoon flag of the new time.
  always_comb begin
    if (lm_zero && (hour_next == '0)) begin
      std12_next = lim.half;
    end else if (lm_zero && (hour_next == lim.lh)) begin
      std12_next = '0;
    end else if (lm_zero && (hour_next > lim.half)) begin
      std12_next = hour_next - lim.half;
    end else if (!lm_zero && (hour_next > lim.half)) begin
      std12_next = hour_next - lim.half - 13'd1;
    end else begin
      std12_next = hour_next;
    end
    if (lm_zero) begin
      pm_next = (hour_next >= lim.half) && (hour_next != lim.lh);
    end else begin
      pm_next = (hour_next > lim.half);
    end
  end

  // Time state.
  always_ff @(posedge clk) begin
    if (rst) begin
      hour_reg <= '0;
      min_tens_reg <= '0;
      min_units_reg <= '0;
      sec_tens_reg <= '0;
      sec_units_reg <= '0;
    end else if (step) begin
      hour_reg <= hour_next;
      min_tens_reg <= min_tens_next;
      min_units_reg <= min_units_next;
      sec_tens_reg <= sec_tens_next;
      sec_units_reg <= sec_units_next;
    end
  end

  // Result register holds until the next request is processed.
  always_ff @(posedge clk) begin
    if (step) begin
      result.hours_now <= hour_next;
      result.minute_tens_now <= min_tens_next;
      result.minute_units_now <= min_units_next;
      result.second_tens_now <= sec_tens_next;
      result.second_units_now <= sec_units_next;
      result.half_day_hours <= std12_next;
      result.is_afternoon <= pm_next;
      result.wrapped <= wrap_next;
    end
  end

  // Digits stay in their decimal ranges.
  a_digits_range: assert property (@(posedge clk) disable iff (rst)
    (sec_units_reg <= UNITS_MAX) && (sec_tens_reg <= TENS_MAX) &&
    (min_units_reg <= UNITS_MAX) && (min_tens_reg <= TENS_MAX))
    else $error("time digit out of range");

  // An even-day wrap returns to midnight.
  a_even_wrap: assert property (@(posedge clk) disable iff (rst)
    (step && (item.kind == KIND_TICK) && wrap_even) |=>
    ((hour_reg == '0) && (sec_units_reg == '0) && (min_tens_reg == '0)))
    else $error("even-day wrap did not reach midnight");

  // A plain tick below the seconds carry bumps the seconds units.
  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    (step && (item.kind == KIND_TICK) && !wrap_even && !wrap_frac && !c_sec_units) |=>
    (sec_units_reg == $past(sec_units_reg) + 4'd1))
    else $error("tick did not advance seconds");

  // A load never reports a wrap.
  a_load_no_wrap: assert property (@(posedge clk) disable iff (rst)
    (step && (item.kind == KIND_LOAD)) |=> !result.wrapped)
    else $error("load reported a wrap");

endmodule

// ----- rtl/configurable_day_length_clock.sv -----
// Top level of the configurable day length clock: handshakes, config and pipeline.
//
//  Channel | Signals                                      | Direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_stall, kind, load_*             | request in
//  out     | out_valid, out_stall, *_now, half_day_hours, | result out
//          | is_afternoon, wrapped                        |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | write in
//
// Every request passes from acceptance through the input register, then through
// the clock logic into the result register.
// One request is accepted in every cycle while the output is taken.
// The pipeline moves as a whole; it holds while a result waits under out_stall.
// Reset is synchronous and sets the time to zero and the day to 24 hours.
// Configuration writes are always taken.
`timescale 1ns / 1ps
module configurable_day_length_clock (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            kind,
  input  logic [cdlc_pkg::HOUR_W-1:0]     load_hours,
  input  logic [cdlc_pkg::TENS_W-1:0]     load_minute_tens,
  input  logic [cdlc_pkg::UNITS_W-1:0]    load_minute_units,
  input  logic [cdlc_pkg::TENS_W-1:0]     load_second_tens,
  input  logic [cdlc_pkg::UNITS_W-1:0]    load_second_units,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cdlc_pkg::HOUR_W-1:0]     hours_now,
  output logic [cdlc_pkg::TENS_W-1:0]     minute_tens_now,
  output logic [cdlc_pkg::UNITS_W-1:0]    minute_units_now,
  output logic [cdlc_pkg::TENS_W-1:0]     second_tens_now,
  output logic [cdlc_pkg::UNITS_W-1:0]    second_units_now,
  output logic [cdlc_pkg::HOUR_W-1:0]     half_day_hours,
  output logic                            is_afternoon,
  output logic                            wrapped,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cdlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdlc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cdlc_pkg::*;

  logic [HOUR_W-1:0]     body_hours;
  logic [BODY_MIN_W-1:0] body_minutes;
  limits_t               lim;
  logic                  advance;
  logic                  s1_valid;
  item_t                 s1_item;
  item_t                 in_item;
  result_t               result;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_hours <= 13'd24;
      body_minutes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BODY_HOURS: body_hours <= cfg_data[HOUR_W-1:0];
        REG_BODY_MINUTES: body_minutes <= cfg_data[BODY_MIN_W-1:0];
        default: ;
      endcase
    end
  end

  cdlc_limits u_limits (
    .body_hours   (body_hours),
    .body_minutes (body_minutes),
    .lim          (lim)
  );

  // The pipeline moves unless a finished result is held back.
  assign advance = !(out_valid && out_stall);
  assign in_stall = !advance;

  assign in_item.kind = kind;
  assign in_item.load_hours = load_hours;
  assign in_item.load_minute_tens = load_minute_tens;
  assign in_item.load_minute_units = load_minute_units;
  assign in_item.load_second_tens = load_second_tens;
  assign in_item.load_second_units = load_second_units;

  // Input register and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item <= in_item;
    end
  end

  cdlc_time_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_valid && advance),
    .item   (s1_item),
    .lim    (lim),
    .result (result)
  );

  assign hours_now = result.hours_now;
  assign minute_tens_now = result.minute_tens_now;
  assign minute_units_now = result.minute_units_now;
  assign second_tens_now = result.second_tens_now;
  assign second_units_now = result.second_units_now;
  assign half_day_hours = result.half_day_hours;
  assign is_afternoon = result.is_afternoon;
  assign wrapped = result.wrapped;

endmodule
